// File: rtl/hmt_pkg.sv
package hmt_pkg;

	localparam int MEMBERS_DEF = 32;
	localparam int ID_W        = 32;
	localparam int PORT_W      = 16;
	localparam int HB_W        = 32;
	localparam int TIME_W      = 32;
	localparam int PERIOD_W    = 16;
	localparam int CNT_OUT_W   = 6;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [HB_W-1:0] HB_FAILED = 32'hFFFF_FFFF;
	localparam logic [HB_W-1:0] HB_MAXPOS = 32'h7FFF_FFFF;

	localparam logic CMD_REPORT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [PERIOD_W-1:0] FAIL_TO_RST   = 16'd5;
	localparam logic [PERIOD_W-1:0] REMOVE_TO_RST = 16'd20;
	localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd4;

	typedef enum logic [1:0] {
		KIND_REPORT  = 2'd0,
		KIND_REMOVED = 2'd1,
		KIND_TICK    = 2'd2
	} hmt_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SELF_ID        = 3'd0,
		REG_SELF_PORT      = 3'd1,
		REG_FAIL_TIMEOUT   = 3'd2,
		REG_REMOVE_TIMEOUT = 3'd3,
		REG_GOSSIP_PERIOD  = 3'd4
	} hmt_reg_t;

	typedef struct packed {
		logic                     cmd;
		logic [ID_W-1:0]          node_id;
		logic [PORT_W-1:0]        node_port;
		logic signed [HB_W-1:0]   heartbeat;
	} hmt_in_t;

	typedef struct packed {
		hmt_kind_t                kind;
		logic [ID_W-1:0]          out_id;
		logic [PORT_W-1:0]        out_port;
		logic                     was_new;
		logic                     table_full;
		logic [CNT_OUT_W-1:0]     member_count;
		logic                     gossip_due;
		logic                     last;
	} hmt_out_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PORT_W-1:0] port;
		logic [HB_W-1:0]   hb;
		logic [TIME_W-1:0] stamp;
	} hmt_ent_t;

	typedef struct packed {
		logic                busy;
		logic [PERIOD_W-1:0] rem;
	} hmt_mod_stat_t;

	function automatic logic hb_less(logic [HB_W-1:0] a, logic [HB_W-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

endpackage

// File: rtl/hmt_ram.sv
module hmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/hmt_mod.sv
module hmt_mod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [hmt_pkg::TIME_W-1:0]       dividend,
	input  logic [hmt_pkg::PERIOD_W-1:0]     divisor,
	output hmt_pkg::hmt_mod_stat_t           stat
);
	import hmt_pkg::*;

	localparam int STEP_W = $clog2(TIME_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	logic [TIME_W-1:0]   quo_q;
	logic [PERIOD_W-1:0] div_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W:0]   trial;
	logic [PERIOD_W-1:0] rem_next;

	// restoring remainder, one dividend bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[TIME_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = PERIOD_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = trial[PERIOD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_q << 1;
			rem_q <= rem_next;
		end
	end

	assign stat = '{busy: busy_q, rem: rem_q};

endmodule

// File: rtl/heartbeat_membership_table_unit.sv
// Heartbeat membership table with failure detection.
// Items enter on start while busy is low; item.cmd selects a heartbeat report
// (node_id, node_port, heartbeat) or a local time tick. Config registers are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high and unknown indexes are dropped. Results appear on
// result for one cycle each, marked by result_valid, and the receiver cannot
// stall them; result.last marks the final one of an item. A report walks every
// slot once through the shared compare unit, then does one update before its
// result. A tick adds a second walk that ages slots and emits one removal
// result per freed slot in slot order, then the tick-done result; the 32-step
// gossip remainder runs alongside, and the tick-done result waits for it.
// One item is in flight at a time: busy drops with the final result.
// Reset empties the table, clears local time and loads the register defaults.
module heartbeat_membership_table_unit #(
	parameter int MEMBERS = hmt_pkg::MEMBERS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  hmt_pkg::hmt_in_t                  item,
	output logic                              result_valid,
	output hmt_pkg::hmt_out_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hmt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hmt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import hmt_pkg::*;

	localparam int IDX_W = $clog2(MEMBERS);
	localparam int CNT_W = $clog2(MEMBERS + 1);
	localparam int ENT_W = $bits(hmt_ent_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEMBERS - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_TIME = 7'b0000010,
		ST_PREP = 7'b0000100,
		ST_SCAN = 7'b0001000,
		ST_UPD  = 7'b0010000,
		ST_WALK = 7'b0100000,
		ST_DONE = 7'b1000000
	} hmt_state_t;

	hmt_state_t          state_q;

	logic [ID_W-1:0]     self_id_q;
	logic [PORT_W-1:0]   self_port_q;
	logic [PERIOD_W-1:0] fail_to_q;
	logic [PERIOD_W-1:0] rm_to_q;
	logic [PERIOD_W-1:0] period_q;

	logic [TIME_W-1:0]   lt_q;
	logic                fail_ok_q;
	logic                rm_ok_q;
	logic [TIME_W-1:0]   fail_thr_q;
	logic [TIME_W-1:0]   rm_thr_q;

	logic                tick_q;
	logic [ID_W-1:0]     key_id_q;
	logic [PORT_W-1:0]   key_port_q;
	logic [HB_W-1:0]     key_hb_q;

	logic [MEMBERS-1:0]  valid_q;
	logic [MEMBERS-1:0]  fail_mask_q;
	logic [MEMBERS-1:0]  rm_mask_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    rm_n_q;

	logic                match_q;
	logic [IDX_W-1:0]    match_idx_q;
	logic [HB_W-1:0]     match_hb_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                was_new_q;
	logic                full_q;

	logic [IDX_W-1:0]    idx_q;
	logic                iss_q;
	logic                chk_vld_s1;
	logic [IDX_W-1:0]    chk_idx_s1;

	logic                result_valid_q;
	hmt_out_t            result_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	hmt_ent_t            ram_wdata;
	hmt_ent_t            ram_rdata;
	logic [ENT_W-1:0]    ram_rbits;

	hmt_mod_stat_t       mod_stat;
	logic                mod_start;

	logic                walking;
	logic                walk_last;
	logic                upd;
	logic                add;
	logic                drop;
	logic                hit;
	logic                fail_aged;
	logic                rm_aged;
	logic [CNT_W-1:0]    rm_eff;
	logic [CNT_W-1:0]    cnt_next;
	logic [TIME_W-1:0]   lt_next;

	assign busy         = state_q != ST_IDLE;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign ram_rdata    = hmt_ent_t'(ram_rbits);
	assign mod_start    = state_q == ST_PREP;

	assign walking   = state_q == ST_SCAN || state_q == ST_WALK;
	assign walk_last = chk_vld_s1 && chk_idx_s1 == LAST_IDX;
	assign lt_next   = lt_q + TIME_W'(lt_q != '1);

	// shared slot compare unit
	assign hit = valid_q[chk_idx_s1] && ram_rdata.id == key_id_q
		&& ram_rdata.port == key_port_q;
	assign fail_aged = tick_q && fail_ok_q && ram_rdata.stamp < fail_thr_q;
	assign rm_aged   = tick_q && rm_ok_q && ram_rdata.stamp < rm_thr_q;

	assign upd  = match_q && match_hb_q != HB_FAILED && hb_less(match_hb_q, key_hb_q);
	assign add  = !match_q && key_hb_q != HB_FAILED && free_q;
	assign drop = !match_q && key_hb_q != HB_FAILED && !free_q;
	assign rm_eff   = rm_n_q - CNT_W'(upd && rm_mask_q[match_idx_q]);
	assign cnt_next = cnt_q + CNT_W'(add) - rm_eff;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = match_idx_q;
		ram_wdata = '{id: key_id_q, port: key_port_q, hb: key_hb_q, stamp: lt_q};
		if (state_q == ST_UPD) begin
			if (upd) begin
				ram_we = 1'b1;
			end else if (add) begin
				ram_we    = 1'b1;
				ram_waddr = free_idx_q;
			end
		end else if (state_q == ST_WALK && chk_vld_s1 && fail_mask_q[chk_idx_s1]) begin
			ram_we       = 1'b1;
			ram_waddr    = chk_idx_s1;
			ram_wdata    = ram_rdata;
			ram_wdata.hb = HB_FAILED;
		end
	end

	hmt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MEMBERS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rbits)
	);

	hmt_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(lt_q),
		.divisor (period_q),
		.stat    (mod_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q   <= '0;
			self_port_q <= '0;
			fail_to_q   <= FAIL_TO_RST;
			rm_to_q     <= REMOVE_TO_RST;
			period_q    <= PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SELF_ID:        self_id_q   <= cfg_data;
				REG_SELF_PORT:      self_port_q <= cfg_data[PORT_W-1:0];
				REG_FAIL_TIMEOUT:   fail_to_q   <= cfg_data[PERIOD_W-1:0];
				REG_REMOVE_TIMEOUT: rm_to_q     <= cfg_data[PERIOD_W-1:0];
				REG_GOSSIP_PERIOD:  period_q    <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// slot walker: read issue, then compare in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			iss_q      <= 1'b0;
			chk_vld_s1 <= 1'b0;
			chk_idx_s1 <= '0;
		end else if (walking && iss_q) begin
			chk_vld_s1 <= 1'b1;
			chk_idx_s1 <= idx_q;
			if (idx_q == LAST_IDX) begin
				iss_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end else begin
			chk_vld_s1 <= 1'b0;
			if ((state_q == ST_IDLE && start) || state_q == ST_PREP
				|| (state_q == ST_UPD && tick_q)) begin
				idx_q <= '0;
				iss_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (state_q == ST_WALK && chk_vld_s1 && rm_mask_q[chk_idx_s1])
				|| (state_q == ST_DONE && (!tick_q || !mod_stat.busy));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			lt_q           <= '0;
			valid_q        <= '0;
			fail_mask_q    <= '0;
			rm_mask_q      <= '0;
			cnt_q          <= '0;
			rm_n_q         <= '0;
			match_q        <= 1'b0;
			free_q         <= 1'b0;
			was_new_q      <= 1'b0;
			full_q         <= 1'b0;
			tick_q         <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						tick_q      <= item.cmd == CMD_TICK;
						match_q     <= 1'b0;
						free_q      <= 1'b0;
						fail_mask_q <= '0;
						rm_mask_q   <= '0;
						rm_n_q      <= '0;
						state_q     <= item.cmd == CMD_TICK ? ST_TIME : ST_SCAN;
					end
				end
				ST_TIME: begin
					lt_q    <= lt_next;
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (chk_vld_s1) begin
						if (valid_q[chk_idx_s1]) begin
							if (!match_q && hit) begin
								match_q <= 1'b1;
							end
							fail_mask_q[chk_idx_s1] <= fail_aged;
							rm_mask_q[chk_idx_s1]   <= rm_aged;
							rm_n_q <= rm_n_q + CNT_W'(rm_aged);
						end else if (!free_q) begin
							free_q <= 1'b1;
						end
					end
					if (walk_last) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					was_new_q <= add;
					full_q    <= drop;
					cnt_q     <= cnt_next;
					if (upd) begin
						fail_mask_q[match_idx_q] <= 1'b0;
						rm_mask_q[match_idx_q]   <= 1'b0;
					end
					if (add) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= tick_q ? ST_WALK : ST_DONE;
				end
				ST_WALK: begin
					if (chk_vld_s1 && rm_mask_q[chk_idx_s1]) begin
						valid_q[chk_idx_s1] <= 1'b0;
					end
					if (walk_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!tick_q || !mod_stat.busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_id_q   <= item.node_id;
			key_port_q <= item.node_port;
			key_hb_q   <= item.heartbeat;
		end
		if (state_q == ST_PREP) begin
			key_id_q   <= self_id_q;
			key_port_q <= self_port_q;
			key_hb_q   <= lt_q[TIME_W-1] ? HB_MAXPOS : lt_q;
			fail_ok_q  <= lt_q >= TIME_W'(fail_to_q);
			rm_ok_q    <= lt_q >= TIME_W'(rm_to_q);
			fail_thr_q <= lt_q - TIME_W'(fail_to_q);
			rm_thr_q   <= lt_q - TIME_W'(rm_to_q);
		end
		if (state_q == ST_SCAN && chk_vld_s1) begin
			if (!match_q && hit) begin
				match_idx_q <= chk_idx_s1;
				match_hb_q  <= ram_rdata.hb;
			end
			if (!valid_q[chk_idx_s1] && !free_q) begin
				free_idx_q <= chk_idx_s1;
			end
		end
		if (state_q == ST_WALK && chk_vld_s1 && rm_mask_q[chk_idx_s1]) begin
			result_q <= '{kind: KIND_REMOVED, out_id: ram_rdata.id,
				out_port: ram_rdata.port, was_new: 1'b0, table_full: 1'b0,
				member_count: CNT_OUT_W'(cnt_q), gossip_due: 1'b0, last: 1'b0};
		end
		if (state_q == ST_DONE) begin
			result_q <= '{kind: tick_q ? KIND_TICK : KIND_REPORT, out_id: '0,
				out_port: '0, was_new: was_new_q, table_full: full_q,
				member_count: CNT_OUT_W'(cnt_q),
				gossip_due: tick_q && period_q != '0 && mod_stat.rem == '0,
				last: 1'b1};
		end
	end

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not make the block busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("final result while still busy");

	a_removed_mid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_REMOVED |-> busy && !result.last)
		else $error("removal result outside a tick");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.member_count <= CNT_OUT_W'(MEMBERS))
		else $error("member count above table size");

endmodule
